// ===== sv/gtc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-coloring counter package
// Shared widths, command codes, color codes and the status bundle that the
// search sequencer hands to the top level.
// ----------------------------------------------------------------------------
package gtc_pkg;

  // Fixed field widths.
  localparam int COUNT_W  = 26;
  localparam int VERTEX_W = 4;
  localparam int CFG_W    = 5;

  // Reset value of the vertex count register.
  localparam logic [CFG_W-1:0] CFG_VERTEX_COUNT_RESET = 5'd16;

  // Command codes.
  localparam logic CMD_ADD_EDGE = 1'b0;
  localparam logic CMD_COUNT    = 1'b1;

  // Vertex colors: three real colors and a code for no color yet.
  typedef logic [1:0] color_t;
  localparam int     NUM_COLORS  = 3;
  localparam color_t COLOR_FIRST = 2'd0;
  localparam color_t COLOR_NONE  = 2'd3;

  typedef logic [COUNT_W-1:0] count_t;

  // Status from the sequencer to the top level.
  typedef struct packed {
    logic   busy;
    logic   done;
    count_t count;
  } seq_status_t;

endpackage

// ===== sv/gtc_adj_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adjacency matrix store
// One row of flip-flops per vertex. Edges are set symmetrically, one row is
// read at a time, the diagonal is exposed for the self-loop check, and the
// whole matrix clears at once on reset or clear.
// ----------------------------------------------------------------------------
module gtc_adj_store #(
  parameter int MAX_VERTICES = 16,
  parameter int VW           = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              edge_we,
  input  logic [gtc_pkg::VERTEX_W-1:0]      vertex_a,
  input  logic [gtc_pkg::VERTEX_W-1:0]      vertex_b,
  input  logic                              clear,
  input  logic [VW-1:0]                     rd_addr,
  output logic [MAX_VERTICES-1:0]           rd_row,
  output logic [MAX_VERTICES-1:0]           diag
);
  import gtc_pkg::*;

  logic [MAX_VERTICES-1:0] rows_r [MAX_VERTICES];

  // Row storage: reset and clear empty the graph, an edge sets bits [a][b] and [b][a].
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        rows_r[i] <= '0;
      end
    end else if (edge_we) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        for (int j = 0; j < MAX_VERTICES; j++) begin
          if ((i == int'(vertex_a) && j == int'(vertex_b)) ||
              (i == int'(vertex_b) && j == int'(vertex_a))) begin
            rows_r[i][j] <= 1'b1;
          end
        end
      end
    end
  end

  // Single row read port.
  assign rd_row = rows_r[rd_addr];

  // Diagonal bits for the self-loop check.
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      diag[i] = rows_r[i][i];
    end
  end

endmodule

// ===== sv/gtc_color_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color step unit
// Given the neighbors of the current vertex, all vertex colors and the color
// the vertex holds now, finds the next color above it that no neighbor uses.
// ----------------------------------------------------------------------------
module gtc_color_check #(
  parameter int MAX_VERTICES = 16
) (
  input  logic [MAX_VERTICES-1:0] neighbors,
  input  gtc_pkg::color_t         colors [MAX_VERTICES],
  input  gtc_pkg::color_t         cur_color,
  output logic                    found,
  output gtc_pkg::color_t         next_color
);
  import gtc_pkg::*;

  logic [NUM_COLORS-1:0] conflict;

  // A color is taken when any neighbor already holds it.
  always_comb begin
    conflict = '0;
    for (int c = 0; c < NUM_COLORS; c++) begin
      for (int u = 0; u < MAX_VERTICES; u++) begin
        if (neighbors[u] && colors[u] == color_t'(c)) begin
          conflict[c] = 1'b1;
        end
      end
    end
  end

  // Lowest free color above the current one; no color yet starts at the first.
  always_comb begin
    found      = 1'b0;
    next_color = COLOR_NONE;
    for (int c = NUM_COLORS - 1; c >= 0; c--) begin
      if (!conflict[c] && (cur_color == COLOR_NONE || color_t'(c) > cur_color)) begin
        found      = 1'b1;
        next_color = color_t'(c);
      end
    end
  end

endmodule

// ===== sv/gtc_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting sequencer
// Walks each connected component depth first to fix the vertex order, then
// backtracks over colorings one step per cycle through the color step unit,
// and folds three times each component count into the running product.
// ----------------------------------------------------------------------------
module gtc_seq #(
  parameter int MAX_VERTICES = 16,
  parameter int VW           = 4,
  parameter int CW           = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [CW-1:0]             n_eff,
  output logic [VW-1:0]             rd_addr,
  input  logic [MAX_VERTICES-1:0]   rd_row,
  input  logic [MAX_VERTICES-1:0]   diag,
  output logic                      clear,
  output gtc_pkg::seq_status_t      status
);
  import gtc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ROOT, S_POP, S_PUSH, S_SEARCH, S_MUL3, S_MUL
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           root_r, root_nxt;
  logic [CW-1:0]           sp_r, sp_nxt;
  logic [CW-1:0]           len_r, len_nxt;
  logic [CW-1:0]           pos_r, pos_nxt;
  logic [VW-1:0]           vcur_r, vcur_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  count_t                  comp_r, comp_nxt;
  count_t                  m3_r, m3_nxt;
  count_t                  total_r, total_nxt;
  count_t                  result_r, result_nxt;
  logic                    done_r, done_nxt;

  color_t                  colors_r [MAX_VERTICES];
  logic [VW-1:0]           order_r  [MAX_VERTICES];
  logic [VW-1:0]           stack_r  [MAX_VERTICES];

  logic                    color_we;
  logic [VW-1:0]           color_waddr;
  color_t                  color_wdata;
  logic                    order_we;
  logic [VW-1:0]           order_waddr;
  logic [VW-1:0]           order_wdata;
  logic                    stack_we;
  logic [VW-1:0]           stack_waddr;
  logic [VW-1:0]           stack_wdata;

  logic [MAX_VERTICES-1:0] act;
  logic [MAX_VERTICES-1:0] nb;
  logic [MAX_VERTICES-1:0] cand;
  logic [MAX_VERTICES-1:0] cand_low;
  logic [VW-1:0]           cand_idx;
  logic [CW-1:0]           sp_m1;
  logic [VW-1:0]           stack_top;
  logic [VW-1:0]           pos_v;
  logic [VW-1:0]           root_idx;
  color_t                  cur_color;
  logic                    step_found;
  color_t                  step_color;
  logic [2*COUNT_W-1:0]    prod;

  // Vertices in use.
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      act[i] = (i < int'(n_eff));
    end
  end

  // Stack top, ordered vertex at the search position, and the root index.
  assign sp_m1     = sp_r - CW'(1);
  assign stack_top = stack_r[sp_m1[VW-1:0]];
  assign pos_v     = order_r[pos_r[VW-1:0]];
  assign root_idx  = root_r[VW-1:0];
  assign cur_color = colors_r[pos_v];

  // One adjacency row is read: the searched vertex or the vertex being expanded.
  assign rd_addr = (state_r == S_SEARCH) ? pos_v : vcur_r;
  assign nb      = rd_row & act;

  // Lowest unvisited neighbor of the expanded vertex.
  assign cand     = nb & ~visited_r;
  assign cand_low = cand & (~cand + MAX_VERTICES'(1));
  always_comb begin
    cand_idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        cand_idx = VW'(i);
      end
    end
  end

  // Color step unit for the search.
  gtc_color_check #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_check (
    .neighbors  (nb),
    .colors     (colors_r),
    .cur_color  (cur_color),
    .found      (step_found),
    .next_color (step_color)
  );

  // Component product step.
  assign prod = (2*COUNT_W)'(total_r) * (2*COUNT_W)'(m3_r);

  // Sequencer next-state logic.
  always_comb begin
    state_nxt   = state_r;
    root_nxt    = root_r;
    sp_nxt      = sp_r;
    len_nxt     = len_r;
    pos_nxt     = pos_r;
    vcur_nxt    = vcur_r;
    visited_nxt = visited_r;
    comp_nxt    = comp_r;
    m3_nxt      = m3_r;
    total_nxt   = total_r;
    result_nxt  = result_r;
    done_nxt    = 1'b0;
    color_we    = 1'b0;
    color_waddr = root_idx;
    color_wdata = COLOR_NONE;
    order_we    = 1'b0;
    order_waddr = len_r[VW-1:0];
    order_wdata = stack_top;
    stack_we    = 1'b0;
    stack_waddr = sp_r[VW-1:0];
    stack_wdata = cand_idx;

    case (state_r)
      S_IDLE: begin
        if (go) begin
          visited_nxt = '0;
          root_nxt    = '0;
          total_nxt   = count_t'(1);
          if (|(diag & act)) begin
            // A self-loop leaves no proper coloring.
            result_nxt = '0;
            done_nxt   = 1'b1;
          end else begin
            state_nxt = S_ROOT;
          end
        end
      end

      S_ROOT: begin
        if (root_r == n_eff) begin
          result_nxt = total_r;
          done_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end else if (visited_r[root_idx]) begin
          root_nxt = root_r + CW'(1);
        end else begin
          visited_nxt[root_idx] = 1'b1;
          stack_we    = 1'b1;
          stack_waddr = '0;
          stack_wdata = root_idx;
          sp_nxt      = CW'(1);
          len_nxt     = '0;
          state_nxt   = S_POP;
        end
      end

      S_POP: begin
        if (sp_r == '0) begin
          // Walk of this component is complete.
          if (len_r == CW'(1)) begin
            comp_nxt  = count_t'(1);
            state_nxt = S_MUL3;
          end else begin
            color_we    = 1'b1;
            color_waddr = root_idx;
            color_wdata = COLOR_FIRST;
            pos_nxt     = CW'(1);
            comp_nxt    = '0;
            state_nxt   = S_SEARCH;
          end
        end else begin
          sp_nxt    = sp_m1;
          order_we  = 1'b1;
          len_nxt   = len_r + CW'(1);
          vcur_nxt  = stack_top;
          state_nxt = S_PUSH;
        end
      end

      S_PUSH: begin
        if (|cand) begin
          visited_nxt = visited_r | cand_low;
          stack_we    = 1'b1;
          sp_nxt      = sp_r + CW'(1);
        end else begin
          state_nxt = S_POP;
        end
      end

      S_SEARCH: begin
        color_we    = 1'b1;
        color_waddr = pos_v;
        if (step_found) begin
          color_wdata = step_color;
          if ((pos_r + CW'(1)) == len_r) begin
            // Last vertex colored: one full coloring.
            comp_nxt = comp_r + count_t'(1);
          end else begin
            pos_nxt = pos_r + CW'(1);
          end
        end else begin
          color_wdata = COLOR_NONE;
          if (pos_r == CW'(1)) begin
            state_nxt = S_MUL3;
          end else begin
            pos_nxt = pos_r - CW'(1);
          end
        end
      end

      S_MUL3: begin
        // Release the root color and scale the count by the root's three colors.
        color_we    = 1'b1;
        color_waddr = root_idx;
        color_wdata = COLOR_NONE;
        m3_nxt      = comp_r + {comp_r[COUNT_W-2:0], 1'b0};
        state_nxt   = S_MUL;
      end

      S_MUL: begin
        total_nxt = prod[COUNT_W-1:0];
        root_nxt  = root_r + CW'(1);
        state_nxt = S_ROOT;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      root_r    <= '0;
      sp_r      <= '0;
      len_r     <= '0;
      pos_r     <= '0;
      vcur_r    <= '0;
      visited_r <= '0;
      comp_r    <= '0;
      m3_r      <= '0;
      total_r   <= count_t'(1);
      result_r  <= '0;
      done_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      root_r    <= root_nxt;
      sp_r      <= sp_nxt;
      len_r     <= len_nxt;
      pos_r     <= pos_nxt;
      vcur_r    <= vcur_nxt;
      visited_r <= visited_nxt;
      comp_r    <= comp_nxt;
      m3_r      <= m3_nxt;
      total_r   <= total_nxt;
      result_r  <= result_nxt;
      done_r    <= done_nxt;
    end
  end

  // Vertex colors start with no color.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        colors_r[i] <= COLOR_NONE;
      end
    end else if (color_we) begin
      colors_r[color_waddr] <= color_wdata;
    end
  end

  // Visit order and walk stack are written before they are read.
  always_ff @(posedge clk) begin
    if (order_we) begin
      order_r[order_waddr] <= order_wdata;
    end
    if (stack_we) begin
      stack_r[stack_waddr] <= stack_wdata;
    end
  end

  // The graph is emptied on the edge that delivers the count.
  assign clear        = done_nxt;
  assign status.busy  = (state_r != S_IDLE);
  assign status.done  = done_r;
  assign status.count = result_r;

endmodule

// ===== sv/graph_three_coloring_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph three-coloring counter
// Loads an undirected graph edge by edge and counts its proper colorings
// with three colors on command, then empties the graph.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken at a rising edge with start high and busy low. With
//   in_cmd at the add-edge code the edge in_vertex_a--in_vertex_b is stored
//   (ignored when either end is at or above the vertex count), and a new word
//   may follow in the next cycle. With the count code busy rises and the
//   sequencer steps the root index once per vertex, walks each component
//   depth first to fix its vertex order, then backtracks one color step per
//   cycle, and folds three times each component count into the product.
//   The result appears on out_coloring_count with out_valid high for one
//   cycle, on the same edge that busy falls; the graph is cleared then too.
//   A self-loop returns 0 in the cycle after the command. The receiver has no
//   way to hold a result back, so the strobe is never delayed.
//   cfg_vertex_count is written through cfg_valid/cfg_ready while idle.
//   Reset empties the graph and sets the vertex count to 16.
// ----------------------------------------------------------------------------
module graph_three_coloring_counter #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_cmd,
  input  logic [gtc_pkg::VERTEX_W-1:0]       in_vertex_a,
  input  logic [gtc_pkg::VERTEX_W-1:0]       in_vertex_b,
  output logic                               out_valid,
  output logic [gtc_pkg::COUNT_W-1:0]        out_coloring_count,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gtc_pkg::CFG_W-1:0]          cfg_vertex_count
);
  import gtc_pkg::*;

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [CFG_W-1:0]        vertex_count_r;
  logic [CW-1:0]           n_eff;
  logic                    accept;
  logic                    edge_we;
  logic                    go;
  logic                    clear;
  logic [VW-1:0]           rd_addr;
  logic [MAX_VERTICES-1:0] rd_row;
  logic [MAX_VERTICES-1:0] diag;
  seq_status_t             status;

  // Vertex count register.
  assign cfg_ready = ~status.busy;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= CFG_VERTEX_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count_r <= cfg_vertex_count;
    end
  end

  // Vertices in use, limited to the matrix size.
  assign n_eff = (int'(vertex_count_r) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                       : CW'(vertex_count_r);

  // Command decode.
  assign accept  = start && !status.busy;
  assign edge_we = accept && (in_cmd == CMD_ADD_EDGE) &&
                   (int'(in_vertex_a) < int'(n_eff)) &&
                   (int'(in_vertex_b) < int'(n_eff));
  assign go      = accept && (in_cmd == CMD_COUNT);

  gtc_adj_store #(
    .MAX_VERTICES (MAX_VERTICES),
    .VW           (VW)
  ) u_adj (
    .clk      (clk),
    .rst_n    (rst_n),
    .edge_we  (edge_we),
    .vertex_a (in_vertex_a),
    .vertex_b (in_vertex_b),
    .clear    (clear),
    .rd_addr  (rd_addr),
    .rd_row   (rd_row),
    .diag     (diag)
  );

  gtc_seq #(
    .MAX_VERTICES (MAX_VERTICES),
    .VW           (VW),
    .CW           (CW)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .n_eff   (n_eff),
    .rd_addr (rd_addr),
    .rd_row  (rd_row),
    .diag    (diag),
    .clear   (clear),
    .status  (status)
  );

  // Result and handshake outputs.
  assign busy               = status.busy;
  assign out_valid          = status.done;
  assign out_coloring_count = status.count;

endmodule
